// ===== hw/rtl/tsd_pkg.sv =====
// ---------------------------------------------------------------------------
// tsd_pkg - shared types and constants of the tar stream deframer
// Block geometry, header field offsets, result kinds and the result record
// passed from the parser to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tsd_pkg;

	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned OFF_W       = $clog2(BLOCK_BYTES);
	localparam int unsigned SIZE_W      = 36;

	localparam logic [OFF_W-1:0] SIZE_OFFSET = OFF_W'(124);
	localparam logic [OFF_W-1:0] SIZE_LAST   = OFF_W'(124 + 11 - 1);
	localparam logic [OFF_W-1:0] TYPE_OFFSET = OFF_W'(156);
	localparam logic [OFF_W-1:0] BLOCK_LAST  = OFF_W'(BLOCK_BYTES - 1);

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_FILE    = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [7:0]        payload_byte;
		logic              last_of_file;
		logic [SIZE_W-1:0] file_size;
	} result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tsd_parser.sv =====
// ---------------------------------------------------------------------------
// tsd_parser - per-byte archive parser
// Holds the block position, phase and size state; works out the result of
// one byte combinationally and updates its state on each accepted beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsd_parser (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     advance,
	input  wire logic [7:0]               archive_byte,
	input  wire logic                     deliver_contents,
	output tsd_pkg::result_t              result
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	localparam int unsigned OW = tsd_pkg::OFF_W;
	localparam int unsigned SW = tsd_pkg::SIZE_W;

	phase_t          phase_q, phase_d;
	logic [OW-1:0]   offset_q, offset_d;
	logic [SW-1:0]   remaining_q, remaining_d;
	logic [SW-1:0]   acc_q, acc_d;
	logic            space_mode_q, space_mode_d;
	logic            started_q, started_d;
	logic            name_empty_q, name_empty_d;
	logic [7:0]      entry_type_q, entry_type_d;
	logic            regular_q, regular_d;
	logic            first_q, first_d;

	logic            is_digit;
	logic            block_end;
	logic [SW-1:0]   shift_add;
	logic [SW-1:0]   byte_ext;
	logic [SW-1:0]   remaining_dec;

	assign is_digit  = (archive_byte >= tsd_pkg::ASCII_ZERO) &&
		(archive_byte <= tsd_pkg::ASCII_NINE);
	assign block_end = (offset_q == tsd_pkg::BLOCK_LAST);
	assign byte_ext  = {{(SW-8){1'b0}}, archive_byte};
	assign shift_add = {acc_q[SW-4:0], 3'b000} + byte_ext -
		{{(SW-8){1'b0}}, tsd_pkg::ASCII_ZERO};
	assign remaining_dec = remaining_q - {{(SW-1){1'b0}}, 1'b1};

	// Next state and result of the current byte
	always_comb begin
		phase_d      = phase_q;
		offset_d     = block_end ? '0 : offset_q + {{(OW-1){1'b0}}, 1'b1};
		remaining_d  = remaining_q;
		acc_d        = acc_q;
		space_mode_d = space_mode_q;
		started_d    = started_q;
		name_empty_d = name_empty_q;
		entry_type_d = entry_type_q;
		regular_d    = regular_q;
		first_d      = first_q;
		result       = '0;
		result.kind  = tsd_pkg::KIND_PAYLOAD;

		case (phase_q)
			PH_HEADER: begin
				if (offset_q == '0) begin
					name_empty_d = (archive_byte == 8'h00);
				end
				// size field: first character picks the parse mode
				if (offset_q == tsd_pkg::SIZE_OFFSET) begin
					started_d = 1'b0;
					if (archive_byte == tsd_pkg::ASCII_SPACE) begin
						space_mode_d = 1'b1;
						acc_d        = '0;
					end else begin
						space_mode_d = 1'b0;
						acc_d        = byte_ext - {{(SW-8){1'b0}}, tsd_pkg::ASCII_ZERO};
					end
				end else if (offset_q > tsd_pkg::SIZE_OFFSET &&
					offset_q <= tsd_pkg::SIZE_LAST) begin
					if (!space_mode_q || started_q || is_digit) begin
						if (space_mode_q) begin
							started_d = 1'b1;
						end
						acc_d = shift_add;
					end
				end
				if (offset_q == tsd_pkg::TYPE_OFFSET) begin
					entry_type_d = archive_byte;
				end
				// header end: report a regular file or end of archive
				if (block_end) begin
					if (!first_q && name_empty_d) begin
						phase_d     = PH_DONE;
						result.valid = 1'b1;
						result.kind  = tsd_pkg::KIND_END;
					end else begin
						first_d     = 1'b0;
						regular_d   = (entry_type_d == tsd_pkg::ASCII_ZERO) ||
							(entry_type_d == 8'h00);
						remaining_d = acc_d;
						if (acc_d != '0) begin
							phase_d = PH_PAYLOAD;
						end
						if (regular_d) begin
							result.valid     = 1'b1;
							result.kind      = tsd_pkg::KIND_FILE;
							result.file_size = acc_d;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				if (remaining_q != '0) begin
					if (regular_q && deliver_contents) begin
						result.valid        = 1'b1;
						result.kind         = tsd_pkg::KIND_PAYLOAD;
						result.payload_byte = archive_byte;
						result.last_of_file = (remaining_dec == '0);
						result.file_size    = acc_q;
					end
					remaining_d = remaining_dec;
				end
				// drop padding, return to headers after the last block
				if (block_end && remaining_d == '0) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				offset_d = offset_q;
			end
		endcase
	end

	// Hold state, advance on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			offset_q     <= '0;
			remaining_q  <= '0;
			acc_q        <= '0;
			space_mode_q <= 1'b0;
			started_q    <= 1'b0;
			name_empty_q <= 1'b0;
			entry_type_q <= 8'h00;
			regular_q    <= 1'b0;
			first_q      <= 1'b1;
		end else if (advance) begin
			phase_q      <= phase_d;
			offset_q     <= offset_d;
			remaining_q  <= remaining_d;
			acc_q        <= acc_d;
			space_mode_q <= space_mode_d;
			started_q    <= started_d;
			name_empty_q <= name_empty_d;
			entry_type_q <= entry_type_d;
			regular_q    <= regular_d;
			first_q      <= first_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tar_stream_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// tar_stream_deframer_unit - tar archive byte stream deframer
// Parses a tar archive arriving one byte per beat and emits file reports,
// payload bytes and an end-of-archive marker.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one archive byte per beat in s_tdata[7:0].
//   Master stream m_*: at most one result beat per input beat. m_tuser holds
//   the kind (payload byte, regular file found, end of archive), m_tlast
//   marks the final payload byte of a file, m_tdata carries the payload
//   byte and the 36-bit parsed file size.
//   APB port: register deliver_contents at address 0 (bit 0), reset 1;
//   write it only while the stream is idle.
//   Throughput: one byte per cycle unless stalled (see Stall); the parser
//   updates all of its state on each accepted byte. A result appears in the
//   cycle after its byte is accepted, held in one output register.
//   Stall: s_tready drops only while a result waits in the output register
//   and m_tready is low; a byte that yields no result still waits for it.
//   Reset: clears the parser to the start of the first header, empties the
//   output register and restores deliver_contents to 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tar_stream_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] archive_byte
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] payload_byte, [43:8] file_size
	output logic             m_tlast,   // last_of_file
	output logic [1:0]       m_tuser,   // [1:0] kind
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned SW = tsd_pkg::SIZE_W;

	logic             deliver_q;
	logic             accept;
	tsd_pkg::result_t result;

	logic             m_valid_q;
	logic [7:0]       byte_q;
	logic [SW-1:0]    size_q;
	logic             last_q;
	tsd_pkg::kind_t   kind_q;

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'h0 : {31'h0, deliver_q};
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			deliver_q <= pwdata[0];
		end
	end

	tsd_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (accept),
		.archive_byte     (s_tdata),
		.deliver_contents (deliver_q),
		.result           (result)
	);

	// Output valid: load on accept, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= result.valid;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept && result.valid) begin
			byte_q <= result.payload_byte;
			size_q <= result.file_size;
			last_q <= result.last_of_file;
			kind_q <= result.kind;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'h0, size_q, byte_q};
	assign m_tlast  = last_q;
	assign m_tuser  = kind_q;

endmodule
`default_nettype wire

// ===== bench/tb_tar_stream_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// tb_tar_stream_deframer_unit - self-checking bench for the tar deframer
// Streams one generated tar entry (a regular file under a header with an
// empty first name and a randomly chosen size encoding, then its padded
// payload block) into the block under random sender bursts and receiver
// stalls. A scoreboard tracks the parse state byte by byte, predicts every
// result beat and compares the beats that leave the block. The
// deliver_contents register is changed while the stream is idle, including
// in the middle of the file.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_tar_stream_deframer_unit;

	localparam int CLK_PERIOD     = 4;
	localparam int DRAIN_CYCLES   = 4;
	localparam int HOLD_CYCLES    = 400;
	localparam int END_WAIT_LIMIT = 5000;
	localparam int CYCLE_LIMIT    = 200000;

	localparam int SW = tsd_pkg::SIZE_W;
	localparam int OW = tsd_pkg::OFF_W;
	localparam int BB = tsd_pkg::BLOCK_BYTES;

	localparam logic [2:0] ADDR_DELIVER_CONTENTS = 3'd0;

	localparam bit [7:0] NAME_EMPTY       = 8'h00;
	localparam bit [7:0] TYPE_REGULAR     = 8'h30;
	localparam bit [7:0] TYPE_REGULAR_OLD = 8'h00;

	typedef enum {AT_HEADER, IN_PAYLOAD, ARCHIVE_DONE} parse_phase_t;
	typedef enum {STYLE_PLAIN, STYLE_SPACED, STYLE_WRAP, STYLE_BORROW} size_style_t;
	typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

	// Tracks the archive parse and holds the result beats still owed
	class deframer_scoreboard;
		typedef struct {
			tsd_pkg::kind_t    kind;
			bit [7:0]          data;
			bit                last;
			bit [SW-1:0]       size;
		} beat_t;

		beat_t due_beats[$];
		int errors;
		int beats_seen;

		bit                deliver;
		parse_phase_t      phase;
		bit [OW-1:0]       offset;
		bit [SW-1:0]       remaining;
		bit [SW-1:0]       size_acc;
		bit                space_mode;
		bit                digits_started;
		bit                name_empty;
		bit [7:0]          entry_type;
		bit                is_regular;
		bit                first_pending;

		function new();
			deliver       = 1'b1;
			phase         = AT_HEADER;
			first_pending = 1'b1;
		endfunction

		task report_mismatch(string msg);
			if (errors < 40)
				$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void expect_beat(tsd_pkg::kind_t kind, bit [7:0] data, bit last,
				bit [SW-1:0] size);
			beat_t b;
			b.kind = kind;
			b.data = data;
			b.last = last;
			b.size = size;
			due_beats.push_back(b);
		endfunction

		function bit [SW-1:0] octal_step(bit [SW-1:0] acc, bit [7:0] ch);
			return (acc << 3) + SW'(ch) - SW'(tsd_pkg::ASCII_ZERO);
		endfunction

		// Advance the parse by one accepted archive byte
		function void take_archive_byte(bit [7:0] b);
			bit is_digit;
			is_digit = (b >= tsd_pkg::ASCII_ZERO) && (b <= tsd_pkg::ASCII_NINE);
			case (phase)
				AT_HEADER: begin
					if (offset == '0)
						name_empty = (b == NAME_EMPTY);
					if (offset == tsd_pkg::SIZE_OFFSET) begin
						digits_started = 1'b0;
						space_mode     = (b == tsd_pkg::ASCII_SPACE);
						size_acc       = space_mode ? '0 : octal_step('0, b);
					end else if (offset > tsd_pkg::SIZE_OFFSET &&
						offset <= tsd_pkg::SIZE_LAST) begin
						if (!space_mode || digits_started || is_digit) begin
							if (space_mode)
								digits_started = 1'b1;
							size_acc = octal_step(size_acc, b);
						end
					end
					if (offset == tsd_pkg::TYPE_OFFSET)
						entry_type = b;
					if (offset != tsd_pkg::BLOCK_LAST) begin
						offset++;
					end else begin
						offset = '0;
						if (!first_pending && name_empty) begin
							phase = ARCHIVE_DONE;
							expect_beat(tsd_pkg::KIND_END, 8'h00, 1'b0, '0);
						end else begin
							first_pending = 1'b0;
							is_regular = (entry_type == TYPE_REGULAR) ||
								(entry_type == TYPE_REGULAR_OLD);
							remaining = size_acc;
							if (remaining != 0)
								phase = IN_PAYLOAD;
							if (is_regular)
								expect_beat(tsd_pkg::KIND_FILE, 8'h00, 1'b0, size_acc);
						end
					end
				end
				IN_PAYLOAD: begin
					if (remaining != 0) begin
						if (is_regular && deliver)
							expect_beat(tsd_pkg::KIND_PAYLOAD, b, remaining == 1,
								size_acc);
						remaining--;
					end
					if (offset != tsd_pkg::BLOCK_LAST) begin
						offset++;
					end else begin
						offset = '0;
						if (remaining == 0)
							phase = AT_HEADER;
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one result beat with the oldest one owed
		task check_result(logic [1:0] kind, logic [7:0] data, logic last,
				logic [SW-1:0] size);
			beat_t want;
			beats_seen++;
			if (due_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %0d: kind %0d data %02h size %0d",
					beats_seen, kind, data, size));
				return;
			end
			want = due_beats.pop_front();
			if (kind !== want.kind)
				report_mismatch($sformatf("beat %0d kind: got %0d, want %0d",
					beats_seen, kind, want.kind));
			if (data !== want.data)
				report_mismatch($sformatf("beat %0d payload byte: got %02h, want %02h",
					beats_seen, data, want.data));
			if (last !== want.last)
				report_mismatch($sformatf("beat %0d last: got %b, want %b",
					beats_seen, last, want.last));
			if (size !== want.size)
				report_mismatch($sformatf("beat %0d file size: got %0d, want %0d",
					beats_seen, size, want.size));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	deframer_scoreboard sb;
	int burst_left;
	int hold_req_count;
	int cycle_count = 0;

	tar_stream_deframer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: stall in changing modes; on request, hold off a waiting beat
	// for a long stretch so that the block backs up into its input
	initial begin
		rx_mode_t ready_mode;
		int mode_left;
		int hold_done_count;
		bit next_ready;
		m_tready        = 1'b0;
		mode_left       = 0;
		hold_done_count = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata[7:0], m_tlast, m_tdata[8 +: SW]);
			@(negedge clk);
			if (hold_done_count < hold_req_count && m_tvalid) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done_count++;
			end else begin
				if (mode_left == 0) begin
					ready_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left  = $urandom_range(20, 300);
				end
				mode_left--;
				case (ready_mode)
					RX_STEADY:    next_ready = 1'b1;
					RX_COIN:      next_ready = 1'($urandom_range(0, 1));
					RX_SPARSE:    next_ready = ($urandom_range(0, 3) == 0);
					default:      next_ready = !m_tready;
				endcase
				m_tready <= next_ready;
			end
		end
	end

	// Offer one byte, opening a new burst after a random gap when due
	task automatic send_byte(input bit [7:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 1500) :
				$urandom_range(1, 40);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_archive_byte(value);
		burst_left--;
		@(negedge clk);
	endtask

	// Stop offering and let every owed beat drain out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (sb.due_beats.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write deliver_contents on the idle block and read it back
	task automatic write_deliver(input bit value);
		wait_drained();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= ADDR_DELIVER_CONTENTS;
		pwdata  <= {31'd0, value};
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.deliver = value;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== value)
			sb.report_mismatch($sformatf("deliver_contents read back %b, want %b",
				prdata[0], value));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Encode a small size as 11 size-field characters in the chosen style
	function automatic bit [10:0][7:0] make_size_field(input bit [SW-1:0] value,
			input size_style_t style);
		bit [10:0][7:0] f;
		bit [SW-1:0] v;
		int ndig;
		int lead;
		int pos;
		int d;
		int kmax;
		int k;
		v = value;
		for (int i = 10; i >= 0; i--) begin
			f[i] = tsd_pkg::ASCII_ZERO + {5'd0, v[2:0]};
			v = v >> 3;
		end
		case (style)
			// a leading character worth a multiple of 2^36 wraps away
			STYLE_WRAP: f[0] = 8'h70 + 8'($urandom_range(0, 2)) * 8'h40;
			// move value from one digit into the next, leaving non-octal chars
			STYLE_BORROW: begin
				repeat (2) begin
					pos  = $urandom_range(7, 10);
					d    = int'(f[pos-1]) - int'(tsd_pkg::ASCII_ZERO);
					kmax = (255 - int'(f[pos])) / 8;
					if (d < kmax)
						kmax = d;
					if (kmax >= 1) begin
						k = $urandom_range(1, kmax);
						f[pos-1] = f[pos-1] - 8'(k);
						f[pos]   = f[pos] + 8'(8 * k);
					end
				end
			end
			// leading space, then skipped non-digits, then the digits
			STYLE_SPACED: begin
				ndig = 0;
				v = value;
				while (v != 0) begin
					ndig++;
					v = v >> 3;
				end
				lead = $urandom_range(0, 10 - ndig);
				f[0] = tsd_pkg::ASCII_SPACE;
				for (int i = 1; i <= lead; i++) begin
					do
						f[i] = 8'($urandom);
					while (f[i] >= tsd_pkg::ASCII_ZERO && f[i] <= tsd_pkg::ASCII_NINE);
				end
			end
			default: ;
		endcase
		return f;
	endfunction

	// Send one header block and the padded payload blocks that it announces
	task automatic send_entry(input bit [7:0] name0, input bit [7:0] type_byte,
			input int size, input size_style_t style, input int flip_at,
			input bit patterned);
		bit [10:0][7:0] field;
		bit [7:0] b;
		int span;
		field = make_size_field(SW'(size), style);
		for (int off = 0; off < BB; off++) begin
			if (off == 0)
				b = name0;
			else if (off >= int'(tsd_pkg::SIZE_OFFSET) && off <= int'(tsd_pkg::SIZE_LAST))
				b = field[off - int'(tsd_pkg::SIZE_OFFSET)];
			else if (off == int'(tsd_pkg::TYPE_OFFSET))
				b = type_byte;
			else
				b = 8'($urandom);
			send_byte(b);
		end
		span = ((size + BB - 1) / BB) * BB;
		for (int i = 0; i < span; i++) begin
			if (i == flip_at)
				write_deliver(!sb.deliver);
			if (patterned) begin
				case (i % 4)
					0:       b = 8'h00;
					1:       b = 8'hFF;
					2:       b = 8'h5A;
					default: b = 8'hA5;
				endcase
			end else begin
				b = 8'($urandom);
			end
			send_byte(b);
		end
	endtask

	initial begin
		int size;
		int flip_at;
		bit [7:0] type_byte;
		int waited;

		sb = new();
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'h00;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		burst_left = 0;
		hold_req_count = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Start the file with delivery off and turn it on partway through
		write_deliver(1'b0);

		// One regular file in a single payload block; the first header has an
		// empty name, which must not end the archive
		size      = $urandom_range(200, 500);
		type_byte = ($urandom_range(0, 1) == 0) ? TYPE_REGULAR : TYPE_REGULAR_OLD;
		flip_at   = $urandom_range(1, size / 2);
		hold_req_count++;
		send_entry(NAME_EMPTY, type_byte, size, size_style_t'($urandom_range(0, 3)),
			flip_at, 1'($urandom_range(0, 1)));
		s_tvalid <= 1'b0;

		waited = 0;
		while (sb.due_beats.size() != 0 && waited < END_WAIT_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.due_beats.size() != 0)
			sb.report_mismatch($sformatf("%0d expected beats never arrived",
				sb.due_beats.size()));

		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
